// ===== rtl/core/dc_motor_speed_pd_drive_defines.svh =====
// ----------------------------------------------------------------------------
// dc_motor_speed_pd_drive_defines
// assertion macros used by the checker file of the speed drive
// ----------------------------------------------------------------------------
`ifndef DC_MOTOR_SPEED_PD_DRIVE_DEFINES_SVH
`define DC_MOTOR_SPEED_PD_DRIVE_DEFINES_SVH

// property that must hold at every edge out of reset
`define DCPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next
`define DCPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// dcpd_pkg
// shared types and codes of the dc motor speed pd drive
// ----------------------------------------------------------------------------
`default_nettype none

package dcpd_pkg;

    // request types
    localparam logic [1:0] REQ_OFF    = 2'd0;
    localparam logic [1:0] REQ_DIRECT = 2'd1;
    localparam logic [1:0] REQ_LOOP   = 2'd2;

    // target word mode bits
    localparam logic [1:0] MODE_COAST = 2'd0;
    localparam logic [1:0] MODE_FWD   = 2'd1;
    localparam logic [1:0] MODE_REV   = 2'd2;
    localparam logic [1:0] MODE_BRAKE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_TARGET_SCALE = 3'd0;
    localparam logic [2:0] CFG_REPORT_SCALE = 3'd1;
    localparam logic [2:0] CFG_GAIN_P       = 3'd2;
    localparam logic [2:0] CFG_GAIN_D       = 3'd3;
    localparam logic [2:0] CFG_DUTY_LIMIT   = 3'd4;
    localparam logic [2:0] CFG_BRAKE_DUTY   = 3'd5;
    localparam logic [2:0] CFG_INVERT_ENC   = 3'd6;
    localparam logic [2:0] CFG_SWAP_OUT     = 3'd7;

    // configuration reset values
    localparam logic [15:0] RST_TARGET_SCALE = 16'd3277;
    localparam logic [15:0] RST_REPORT_SCALE = 16'd5120;
    localparam logic [15:0] RST_GAIN_P       = 16'd256;
    localparam logic [15:0] RST_GAIN_D       = 16'd0;
    localparam logic [10:0] RST_DUTY_LIMIT   = 11'd1000;
    localparam logic [10:0] RST_BRAKE_DUTY   = 11'd1000;

    // speed report
    localparam logic [13:0] SPEED_MAG_MAX = 14'h3FFF;
    localparam logic [1:0]  SIGN_POS      = 2'b01;
    localparam logic [1:0]  SIGN_NEG      = 2'b10;

    typedef struct packed {
        logic [15:0] target_scale;
        logic [15:0] report_scale;
        logic [15:0] gain_p;
        logic [15:0] gain_d;
        logic [10:0] duty_limit;
        logic [10:0] brake_duty;
        logic        invert_encoder;
        logic        swap_outputs;
    } t_cfg;

    // operand pair for the shared multiplier
    typedef enum logic [1:0] {
        MUL_SPD = 2'd0,
        MUL_TGT = 2'd1,
        MUL_PGN = 2'd2,
        MUL_DGN = 2'd3
    } t_mul_sel;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     spd_en;
        logic     err_en;
        logic     pterm_en;
        logic     fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/dcpd_cfg.sv =====
// ----------------------------------------------------------------------------
// dcpd_cfg
// configuration register file, written through a plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module dcpd_cfg
    import dcpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TARGET_SCALE: n_cfg.target_scale   = i_cfg_data;
                CFG_REPORT_SCALE: n_cfg.report_scale   = i_cfg_data;
                CFG_GAIN_P:       n_cfg.gain_p         = i_cfg_data;
                CFG_GAIN_D:       n_cfg.gain_d         = i_cfg_data;
                CFG_DUTY_LIMIT:   n_cfg.duty_limit     = i_cfg_data[10:0];
                CFG_BRAKE_DUTY:   n_cfg.brake_duty     = i_cfg_data[10:0];
                CFG_INVERT_ENC:   n_cfg.invert_encoder = i_cfg_data[0];
                CFG_SWAP_OUT:     n_cfg.swap_outputs   = i_cfg_data[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    // registers with their reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_scale   <= RST_TARGET_SCALE;
            r_cfg.report_scale   <= RST_REPORT_SCALE;
            r_cfg.gain_p         <= RST_GAIN_P;
            r_cfg.gain_d         <= RST_GAIN_D;
            r_cfg.duty_limit     <= RST_DUTY_LIMIT;
            r_cfg.brake_duty     <= RST_BRAKE_DUTY;
            r_cfg.invert_encoder <= 1'b0;
            r_cfg.swap_outputs   <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/dcpd_ctrl.sv =====
// ----------------------------------------------------------------------------
// dcpd_ctrl
// tick sequencer: steps the shared multiplier through speed, target and gains
// ----------------------------------------------------------------------------
`default_nettype none

module dcpd_ctrl
    import dcpd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  t_sts      i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SPD  = 7'b0000010,
        S_TGT  = 7'b0000100,
        S_ERR  = 7'b0001000,
        S_PGN  = 7'b0010000,
        S_DGN  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_SPD;
        o_ready       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SPD;
                end
            end
            S_SPD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SPD;
                n_state       = S_TGT;
            end
            S_TGT: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_TGT;
                o_cmd.spd_en  = 1'b1;
                n_state       = S_ERR;
            end
            S_ERR: begin
                o_cmd.err_en = 1'b1;
                n_state      = S_PGN;
            end
            S_PGN: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_PGN;
                n_state       = S_DGN;
            end
            S_DGN: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_DGN;
                o_cmd.pterm_en = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                // wait here while the previous result has not been taken
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/dcpd_datapath.sv =====
// ----------------------------------------------------------------------------
// dcpd_datapath
// shared multiplier, error and pd accumulation, duty split and output register
// ----------------------------------------------------------------------------
`default_nettype none

module dcpd_datapath
    import dcpd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  t_cfg                    i_cfg,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [15:0]        i_target_word,
    input  wire logic signed [15:0] i_encoder_count,
    input  wire logic signed [15:0] i_drive_command,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [10:0]             o_duty_a,
    output logic [10:0]             o_duty_b,
    output logic signed [11:0]      o_drive_out,
    output logic [15:0]             o_speed_word
);

    // saturate to +/- the duty limit
    function automatic logic signed [11:0] clamp_lim(input logic signed [26:0] x,
                                                     input logic [10:0] lim);
        logic signed [26:0] lim_s;
        lim_s = signed'({16'b0, lim});
        if (x > lim_s) begin
            return signed'({1'b0, lim});
        end else if (x < -lim_s) begin
            return -signed'({1'b0, lim});
        end
        return x[11:0];
    endfunction

    // item registers
    logic [1:0]         r_req;
    logic [15:0]        r_tword;
    logic signed [16:0] r_pulses;
    logic signed [15:0] r_cmd;

    // working registers
    logic signed [33:0] r_prod;
    logic [15:0]        r_speed;
    logic signed [16:0] r_err;
    logic signed [25:0] r_pterm;

    // loop state
    logic signed [11:0] r_level;
    logic signed [16:0] r_last;
    logic signed [11:0] n_level;
    logic signed [16:0] n_last;

    // output register
    logic               r_out_valid;
    logic [10:0]        r_duty_a;
    logic [10:0]        r_duty_b;
    logic signed [11:0] r_drive_out;
    logic [15:0]        r_speed_word;

    logic signed [16:0] w_enc_ext;
    logic signed [16:0] w_abs;
    logic signed [16:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [33:0] w_prod;
    logic [23:0]        w_spd_q;
    logic [13:0]        w_spd_mag;
    logic [15:0]        w_speed;
    logic signed [16:0] w_tgt;
    logic signed [16:0] w_err;
    logic signed [25:0] w_dterm;
    logic signed [26:0] w_acc;
    logic               w_brake;
    logic [10:0]        w_brk_duty;
    logic [10:0]        w_fwd;
    logic [10:0]        w_rev;
    logic signed [11:0] w_neg_level;

    assign w_enc_ext = {i_encoder_count[15], i_encoder_count};
    assign w_abs     = r_pulses[16] ? -r_pulses : r_pulses;

    // shared multiplier operand select
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_SPD: begin
                w_mul_a = signed'({1'b0, w_abs[15:0]});
                w_mul_b = signed'({1'b0, i_cfg.report_scale});
            end
            MUL_TGT: begin
                w_mul_a = signed'({3'b0, r_tword[13:0]});
                w_mul_b = signed'({1'b0, i_cfg.target_scale});
            end
            MUL_PGN: begin
                w_mul_a = r_err;
                w_mul_b = signed'({1'b0, i_cfg.gain_p});
            end
            MUL_DGN: begin
                w_mul_a = r_last;
                w_mul_b = signed'({1'b0, i_cfg.gain_d});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // speed report from the scaled magnitude product
    assign w_spd_q   = r_prod[31:8];
    assign w_spd_mag = (|w_spd_q[23:14]) ? SPEED_MAG_MAX : w_spd_q[13:0];
    always_comb begin
        if (w_spd_q == '0) begin
            w_speed = {r_tword[15:14], 14'b0};
        end else if (r_pulses[16]) begin
            w_speed = {SIGN_NEG, w_spd_mag};
        end else begin
            w_speed = {SIGN_POS, w_spd_mag};
        end
    end

    // pulse error from the scaled target product
    assign w_tgt = signed'({3'b0, r_prod[29:16]});
    assign w_err = (r_tword[15:14] == MODE_REV) ? (-w_tgt - r_pulses) : (w_tgt - r_pulses);

    // incremental pd sum
    assign w_dterm = r_prod[33:8];
    assign w_acc   = 27'(r_level) + 27'(r_pterm) - 27'(w_dterm);

    // new drive level and error memory per request
    always_comb begin
        n_level = r_level;
        n_last  = r_last;
        w_brake = 1'b0;
        priority if (r_req == REQ_DIRECT) begin
            n_level = clamp_lim(27'(r_cmd), i_cfg.duty_limit);
        end else if (r_req == REQ_LOOP) begin
            unique case (r_tword[15:14])
                MODE_COAST: n_level = '0;
                MODE_BRAKE: begin
                    n_level = '0;
                    w_brake = 1'b1;
                end
                default: begin
                    n_level = clamp_lim(w_acc, i_cfg.duty_limit);
                    n_last  = r_err;
                end
            endcase
        end else begin
            n_level = '0;
            n_last  = '0;
        end
    end

    // bridge duty split
    assign w_brk_duty  = (i_cfg.brake_duty < i_cfg.duty_limit) ? i_cfg.brake_duty
                                                                : i_cfg.duty_limit;
    assign w_neg_level = -n_level;
    always_comb begin
        if (w_brake) begin
            w_fwd = w_brk_duty;
            w_rev = w_brk_duty;
        end else if (n_level[11]) begin
            w_fwd = '0;
            w_rev = w_neg_level[10:0];
        end else begin
            w_fwd = n_level[10:0];
            w_rev = '0;
        end
    end

    // item capture and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req_type;
            r_tword  <= i_target_word;
            r_pulses <= i_cfg.invert_encoder ? -w_enc_ext : w_enc_ext;
            r_cmd    <= i_drive_command;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        if (i_cmd.spd_en) begin
            r_speed <= w_speed;
        end
        if (i_cmd.err_en) begin
            r_err <= w_err;
        end
        if (i_cmd.pterm_en) begin
            r_pterm <= r_prod[33:8];
        end
    end

    // loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_last  <= '0;
        end else if (i_cmd.fin) begin
            r_level <= n_level;
            r_last  <= n_last;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_duty_a     <= i_cfg.swap_outputs ? w_rev : w_fwd;
            r_duty_b     <= i_cfg.swap_outputs ? w_fwd : w_rev;
            r_drive_out  <= n_level;
            r_speed_word <= r_speed;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_duty_a       = r_duty_a;
    assign o_duty_b       = r_duty_b;
    assign o_drive_out    = r_drive_out;
    assign o_speed_word   = r_speed_word;

endmodule

`default_nettype wire

// ===== rtl/core/dc_motor_speed_pd_drive.sv =====
// One control tick per input transfer; the result is registered after states S_SPD to S_FIN.
// The single shared 17x17 multiplier is stepped through speed scale, target scale, p gain and
// d gain; a new item is taken only after the previous one has reached the output register.
// A result held in the output register stalls only the final state S_FIN of the next item.
// Synchronous active-low reset: config to defaults, drive level and last error to zero.
// ----------------------------------------------------------------------------
// dc_motor_speed_pd_drive
// dc motor speed drive with incremental pd loop and h-bridge duty outputs
// ----------------------------------------------------------------------------
`default_nettype none

module dc_motor_speed_pd_drive
    import dcpd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // configuration
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [15:0]        i_cfg_data,
    // input channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [15:0]        i_target_word,
    input  wire logic signed [15:0] i_encoder_count,
    input  wire logic signed [15:0] i_drive_command,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [10:0]             o_duty_a,
    output logic [10:0]             o_duty_b,
    output logic signed [11:0]      o_drive_out,
    output logic [15:0]             o_speed_word
);

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_sts w_sts;

    // configuration registers
    dcpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // tick sequencer
    dcpd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // arithmetic and output register
    dcpd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (w_cfg),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_req_type      (i_req_type),
        .i_target_word   (i_target_word),
        .i_encoder_count (i_encoder_count),
        .i_drive_command (i_drive_command),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_duty_a        (o_duty_a),
        .o_duty_b        (o_duty_b),
        .o_drive_out     (o_drive_out),
        .o_speed_word    (o_speed_word)
    );

endmodule

`default_nettype wire

// ===== rtl/core/dcpd_checker.sv =====
// ----------------------------------------------------------------------------
// dcpd_checker
// port-level checks of the speed drive, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "dc_motor_speed_pd_drive_defines.svh"

module dcpd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic [10:0]        o_duty_a,
    input wire logic [10:0]        o_duty_b,
    input wire logic signed [11:0] o_drive_out,
    input wire logic [15:0]        o_speed_word
);

    logic signed [11:0] w_neg_drive;
    logic [10:0]        w_drive_mag;

    assign w_neg_drive = -o_drive_out;
    assign w_drive_mag = o_drive_out[11] ? w_neg_drive[10:0] : o_drive_out[10:0];

    // a stalled result keeps its payload
    `DCPD_ASSERT_NEXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_duty_a) && $stable(o_duty_b) && $stable(o_drive_out)
        && $stable(o_speed_word), "result changed while stalled")

    // one item at a time: no transfer right after a transfer
    `DCPD_ASSERT_NEXT(a_one_item, i_valid && o_ready, !o_ready,
        "input ready straight after a transfer")

    // the bridge is never driven two ways at different duties
    `DCPD_ASSERT(a_bridge_safe,
        !o_valid || o_duty_a == 11'd0 || o_duty_b == 11'd0 || o_duty_a == o_duty_b,
        "both bridge outputs driven at different duties")

    // a nonzero drive level shows on exactly one output at its magnitude
    `DCPD_ASSERT(a_duty_level,
        !o_valid || o_drive_out == 12'sd0
        || (o_duty_a == w_drive_mag && o_duty_b == 11'd0)
        || (o_duty_b == w_drive_mag && o_duty_a == 11'd0),
        "duty does not match drive level")

endmodule

bind dc_motor_speed_pd_drive dcpd_checker u_dcpd_checker (.*);

`default_nettype wire
